// ----- rtl/segment_box_clip_assert.svh -----
// ----------------------------------------------------------------------------
// segment_box_clip assertion macros
// shared property forms for the segment clipper checks
// ----------------------------------------------------------------------------
`ifndef SEGMENT_BOX_CLIP_ASSERT_SVH
`define SEGMENT_BOX_CLIP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SBC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("segment_box_clip: check failed");

// next-cycle implication, disabled during reset
`define SBC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("segment_box_clip: check failed");

`endif

// ----- rtl/sbc_pkg.sv -----
// ----------------------------------------------------------------------------
// sbc_pkg
// types and constants of the segment box clipper
// ----------------------------------------------------------------------------
package sbc_pkg;

    localparam int COORD_BITS_DEF = 32;

    // hit count codes
    localparam logic [1:0] HIT_NONE  = 2'd0;
    localparam logic [1:0] HIT_POINT = 2'd1;
    localparam logic [1:0] HIT_SEG   = 2'd2;

    typedef struct packed {
        logic signed [31:0] seg_start_x;
        logic signed [31:0] seg_start_y;
        logic signed [31:0] seg_end_x;
        logic signed [31:0] seg_end_y;
        logic signed [31:0] box_low_x;
        logic signed [31:0] box_low_y;
        logic signed [31:0] box_high_x;
        logic signed [31:0] box_high_y;
        logic               solid_box;
    } t_sbc_in;

    typedef struct packed {
        logic        [1:0]  hit_count;
        logic signed [31:0] first_x;
        logic signed [31:0] first_y;
        logic signed [31:0] second_x;
        logic signed [31:0] second_y;
    } t_sbc_out;

endpackage

// ----- rtl/segment_box_clip.sv -----
// ----------------------------------------------------------------------------
// segment_box_clip
// pipelined clipping of a 2d segment against an axis-aligned box
// ----------------------------------------------------------------------------
// One item enters per clock and one result leaves per clock; o_busy is never
// raised. An item accepted at one edge has its result on o_result, with
// o_valid high for exactly one cycle; there is no way to hold it, so the
// receiver must take it. On its way the item passes through the entry
// register, the four slab steps (a multiply stage and an update stage each),
// one stage of cross products, the divider load stage, the restoring
// dividers that turn the clip parameters into rounded endpoints (one
// quotient bit per stage, COORD_BITS stages) and the output register.
// Only the low COORD_BITS bits of each coordinate are used, read as two's
// complement.
// ----------------------------------------------------------------------------
`include "segment_box_clip_assert.svh"

module segment_box_clip #(
    parameter int COORD_BITS = sbc_pkg::COORD_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  sbc_pkg::t_sbc_in i_item,
    output logic             o_busy,
    output logic             o_valid,
    output sbc_pkg::t_sbc_out o_result
);

    localparam int CB  = COORD_BITS;
    localparam int PW  = 2 * CB + 2;   // signed cross product width
    localparam int LAT = CB + 12;      // accept to result, in cycles

    // clip state carried through the slab steps
    typedef struct packed {
        logic signed [CB-1:0]  sx;
        logic signed [CB-1:0]  sy;
        logic signed [CB:0]    dx;
        logic signed [CB:0]    dy;
        logic [3:0][CB:0]      num;   // slab offsets, signed
        logic signed [CB:0]    t0n;
        logic signed [CB:0]    t0d;
        logic signed [CB:0]    t1n;
        logic signed [CB:0]    t1d;
        logic                  solid;
        logic                  moved;
        logic                  keep;
    } t_clip;

    // divider lanes: 0 first x, 1 first y, 2 second x, 3 second y
    typedef struct packed {
        logic [3:0][CB-1:0]    rem;
        logic [3:0][CB-1:0]    low;
        logic [3:0][CB-1:0]    quo;
        logic [CB-1:0]         d0;
        logic [CB-1:0]         d1;
        logic signed [CB-1:0]  sx;
        logic signed [CB-1:0]  sy;
        logic                  xneg;
        logic                  yneg;
        logic [1:0]            cnt;
    } t_div;

    function automatic logic [CB-1:0] mag(input logic signed [CB:0] v);
        logic signed [CB:0] a;
        a = (v < 0) ? -v : v;
        return a[CB-1:0];
    endfunction

    assign o_busy = 1'b0;

    // ------------------------------------------------------------------
    // entry stage: coordinate deltas and slab offsets
    // ------------------------------------------------------------------
    logic signed [CB-1:0] in_sx, in_sy, in_ex, in_ey, in_lx, in_ly, in_hx, in_hy;
    t_clip n_a0;

    assign in_sx = i_item.seg_start_x[CB-1:0];
    assign in_sy = i_item.seg_start_y[CB-1:0];
    assign in_ex = i_item.seg_end_x[CB-1:0];
    assign in_ey = i_item.seg_end_y[CB-1:0];
    assign in_lx = i_item.box_low_x[CB-1:0];
    assign in_ly = i_item.box_low_y[CB-1:0];
    assign in_hx = i_item.box_high_x[CB-1:0];
    assign in_hy = i_item.box_high_y[CB-1:0];

    always_comb begin
        n_a0.sx     = in_sx;
        n_a0.sy     = in_sy;
        n_a0.dx     = (CB+1)'(in_ex) - (CB+1)'(in_sx);
        n_a0.dy     = (CB+1)'(in_ey) - (CB+1)'(in_sy);
        n_a0.num[0] = (CB+1)'(in_lx) - (CB+1)'(in_sx);
        n_a0.num[1] = (CB+1)'(in_sx) - (CB+1)'(in_hx);
        n_a0.num[2] = (CB+1)'(in_ly) - (CB+1)'(in_sy);
        n_a0.num[3] = (CB+1)'(in_sy) - (CB+1)'(in_hy);
        n_a0.t0n    = '0;
        n_a0.t0d    = (CB+1)'(1);
        // a zero-length segment has only t = 0
        n_a0.t1n    = (in_ex == in_sx && in_ey == in_sy) ? '0 : (CB+1)'(1);
        n_a0.t1d    = (CB+1)'(1);
        n_a0.solid  = i_item.solid_box;
        n_a0.moved  = 1'b0;
        n_a0.keep   = 1'b1;
    end

    t_clip r_a [0:4];
    logic  r_a_vld [0:4];
    t_clip r_m [0:3];
    logic  r_m_vld [0:3];
    logic signed [PW-1:0] r_m_p0l [0:3];
    logic signed [PW-1:0] r_m_p0r [0:3];
    logic signed [PW-1:0] r_m_p1l [0:3];
    logic signed [PW-1:0] r_m_p1r [0:3];

    always_ff @(posedge i_clk) begin
        r_a[0] <= n_a0;
    end

    // ------------------------------------------------------------------
    // slab steps: x low, x high, y low, y high
    // each step: cross products, then narrow [t0, t1]
    // ------------------------------------------------------------------
    for (genvar k = 0; k < 4; k++) begin : g_slab
        logic signed [CB:0] a_dir, a_den, a_num;
        logic signed [CB:0] m_dir, m_den, m_num;
        logic               gt0, gt1;
        t_clip              n_u;

        assign a_dir = (k < 2) ? r_a[k].dx : r_a[k].dy;
        assign a_den = ((k % 2) == 0) ? a_dir : -a_dir;
        assign a_num = $signed(r_a[k].num[k]);

        always_ff @(posedge i_clk) begin
            r_m[k]     <= r_a[k];
            r_m_p0l[k] <= a_num * r_a[k].t0d;
            r_m_p0r[k] <= a_den * r_a[k].t0n;
            r_m_p1l[k] <= a_num * r_a[k].t1d;
            r_m_p1r[k] <= a_den * r_a[k].t1n;
        end

        assign m_dir = (k < 2) ? r_m[k].dx : r_m[k].dy;
        assign m_den = ((k % 2) == 0) ? m_dir : -m_dir;
        assign m_num = $signed(r_m[k].num[k]);
        assign gt0   = r_m_p0l[k] > r_m_p0r[k];
        assign gt1   = r_m_p1l[k] > r_m_p1r[k];

        always_comb begin
            n_u = r_m[k];
            if (r_m[k].keep) begin
                priority if (m_den > 0) begin
                    // entering bound: may raise t0
                    if (gt1) begin
                        n_u.keep = 1'b0;
                    end else if (gt0) begin
                        n_u.t0n   = m_num;
                        n_u.t0d   = m_den;
                        n_u.moved = 1'b1;
                    end
                end else if (m_den < 0) begin
                    // leaving bound: may lower t1
                    if (gt0) begin
                        n_u.keep = 1'b0;
                    end else if (gt1) begin
                        n_u.t1n   = -m_num;
                        n_u.t1d   = -m_den;
                        n_u.moved = 1'b1;
                    end
                end else begin
                    // parallel to the slab: inside or not at all
                    n_u.keep = (m_num <= 0);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_a[k+1] <= n_u;
        end
    end

    // ------------------------------------------------------------------
    // final products: t1 vs t0, and offsets t * direction
    // ------------------------------------------------------------------
    logic                 r_f_vld;
    logic                 r_f_hit;
    logic signed [PW-1:0] r_f_cl, r_f_cr;
    logic [2*CB-1:0]      r_f_p [0:3];
    logic [CB-1:0]        r_f_d0, r_f_d1;
    logic signed [CB-1:0] r_f_sx, r_f_sy;
    logic                 r_f_xneg, r_f_yneg;

    always_ff @(posedge i_clk) begin
        r_f_hit  <= r_a[4].keep && (r_a[4].solid || r_a[4].moved);
        r_f_cl   <= r_a[4].t1n * r_a[4].t0d;
        r_f_cr   <= r_a[4].t0n * r_a[4].t1d;
        r_f_p[0] <= mag(r_a[4].t0n) * mag(r_a[4].dx);
        r_f_p[1] <= mag(r_a[4].t0n) * mag(r_a[4].dy);
        r_f_p[2] <= mag(r_a[4].t1n) * mag(r_a[4].dx);
        r_f_p[3] <= mag(r_a[4].t1n) * mag(r_a[4].dy);
        r_f_d0   <= r_a[4].t0d[CB-1:0];
        r_f_d1   <= r_a[4].t1d[CB-1:0];
        r_f_sx   <= r_a[4].sx;
        r_f_sy   <= r_a[4].sy;
        r_f_xneg <= r_a[4].dx < 0;
        r_f_yneg <= r_a[4].dy < 0;
    end

    // ------------------------------------------------------------------
    // restoring dividers, one quotient bit per stage
    // the quotient never exceeds |direction|, so the upper half of the
    // dividend already sits below the divisor
    // ------------------------------------------------------------------
    t_div r_d [0:CB];
    logic r_d_vld [0:CB];
    t_div n_d0;

    always_comb begin
        n_d0.d0   = r_f_d0;
        n_d0.d1   = r_f_d1;
        n_d0.sx   = r_f_sx;
        n_d0.sy   = r_f_sy;
        n_d0.xneg = r_f_xneg;
        n_d0.yneg = r_f_yneg;
        if (!r_f_hit) begin
            n_d0.cnt = sbc_pkg::HIT_NONE;
        end else if (r_f_cl > r_f_cr) begin
            n_d0.cnt = sbc_pkg::HIT_SEG;
        end else begin
            n_d0.cnt = sbc_pkg::HIT_POINT;
        end
        for (int l = 0; l < 4; l++) begin
            n_d0.rem[l] = r_f_p[l][2*CB-1:CB];
            n_d0.low[l] = r_f_p[l][CB-1:0];
            n_d0.quo[l] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d[0] <= n_d0;
    end

    for (genvar j = 0; j < CB; j++) begin : g_div
        t_div n_dj;

        always_comb begin
            logic [CB:0] trial;
            logic [CB:0] dd;
            n_dj = r_d[j];
            for (int l = 0; l < 4; l++) begin
                trial = {r_d[j].rem[l], r_d[j].low[l][CB-1]};
                dd    = {1'b0, (l < 2) ? r_d[j].d0 : r_d[j].d1};
                if (trial >= dd) begin
                    n_dj.rem[l] = CB'(trial - dd);
                    n_dj.quo[l] = {r_d[j].quo[l][CB-2:0], 1'b1};
                end else begin
                    n_dj.rem[l] = trial[CB-1:0];
                    n_dj.quo[l] = {r_d[j].quo[l][CB-2:0], 1'b0};
                end
                n_dj.low[l] = {r_d[j].low[l][CB-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            r_d[j+1] <= n_dj;
        end
    end

    // ------------------------------------------------------------------
    // rounding (ties away from the start) and endpoint assembly
    // ------------------------------------------------------------------
    sbc_pkg::t_sbc_out n_out, r_out;
    logic              r_out_vld;

    always_comb begin
        logic signed [CB+1:0] pt [0:3];
        logic [CB:0]          q1;
        logic [CB-1:0]        den;
        logic                 up, neg;
        logic signed [CB+1:0] base;
        for (int l = 0; l < 4; l++) begin
            den  = (l < 2) ? r_d[CB].d0 : r_d[CB].d1;
            up   = {r_d[CB].rem[l], 1'b0} >= {1'b0, den};
            q1   = {1'b0, r_d[CB].quo[l]} + (CB+1)'(up);
            neg  = ((l % 2) == 0) ? r_d[CB].xneg : r_d[CB].yneg;
            base = ((l % 2) == 0) ? (CB+2)'(r_d[CB].sx) : (CB+2)'(r_d[CB].sy);
            pt[l] = neg ? base - $signed({1'b0, q1}) : base + $signed({1'b0, q1});
        end
        n_out.hit_count = r_d[CB].cnt;
        unique case (r_d[CB].cnt)
            sbc_pkg::HIT_SEG: begin
                n_out.first_x  = 32'(pt[0]);
                n_out.first_y  = 32'(pt[1]);
                n_out.second_x = 32'(pt[2]);
                n_out.second_y = 32'(pt[3]);
            end
            sbc_pkg::HIT_POINT: begin
                n_out.first_x  = 32'(pt[0]);
                n_out.first_y  = 32'(pt[1]);
                n_out.second_x = 32'(pt[0]);
                n_out.second_y = 32'(pt[1]);
            end
            default: begin
                n_out.hit_count = sbc_pkg::HIT_NONE;
                n_out.first_x   = '0;
                n_out.first_y   = '0;
                n_out.second_x  = '0;
                n_out.second_y  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // valid bits travel alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= 4; s++) r_a_vld[s] <= 1'b0;
            for (int s = 0; s < 4; s++)  r_m_vld[s] <= 1'b0;
            for (int s = 0; s <= CB; s++) r_d_vld[s] <= 1'b0;
            r_f_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_a_vld[0] <= i_start && !o_busy;
            for (int s = 0; s < 4; s++) begin
                r_m_vld[s]   <= r_a_vld[s];
                r_a_vld[s+1] <= r_m_vld[s];
            end
            r_f_vld    <= r_a_vld[4];
            r_d_vld[0] <= r_f_vld;
            for (int s = 0; s < CB; s++) r_d_vld[s+1] <= r_d_vld[s];
            r_out_vld  <= r_d_vld[CB];
        end
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    logic out_miss, out_point, out_zero, out_same;

    assign out_miss  = o_valid && o_result.hit_count == sbc_pkg::HIT_NONE;
    assign out_point = o_valid && o_result.hit_count == sbc_pkg::HIT_POINT;
    assign out_zero  = o_result.first_x == '0 && o_result.first_y == '0 &&
                       o_result.second_x == '0 && o_result.second_y == '0;
    assign out_same  = o_result.second_x == o_result.first_x &&
                       o_result.second_y == o_result.first_y;

    `SBC_ASSERT_IMP(a_latency, i_clk, i_rst_n, o_valid, $past(i_start, LAT))
    `SBC_ASSERT_IMP(a_miss_zero, i_clk, i_rst_n, out_miss, out_zero)
    `SBC_ASSERT_IMP(a_point_same, i_clk, i_rst_n, out_point, out_same)
    `SBC_ASSERT_NXT(a_div_to_out, i_clk, i_rst_n, r_d_vld[CB], o_valid && o_result.hit_count == $past(r_d[CB].cnt))

endmodule
